@@ design/kwms_pkg.sv @@
// shared types and constants of the k-way merge selector
package kwms_pkg;

  localparam int unsigned DefMaxSources = 16;
  localparam int unsigned ValueW        = 64;
  localparam int unsigned SourceW       = 4;
  localparam int unsigned NumSrcW       = 5;
  localparam int unsigned MaskW         = 16;
  localparam int unsigned ApbAddrW      = 3;
  localparam int unsigned ApbDataW      = 32;

  localparam logic [0:0] RegNumSources = 1'b0;

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_POP
  } state_e;

  typedef struct packed {
    logic insert;
    logic pop;
    logic finish;
  } dp_cmd_t;

  typedef struct packed {
    logic emit_ok;
    logic queue_nonempty;
    logic all_exhausted;
    logic out_free;
  } dp_status_t;

endpackage

@@ design/kwms_ctrl.sv @@
// control state machine of the k-way merge selector
module kwms_ctrl
  import kwms_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  dp_status_t status_i,
  output dp_cmd_t    cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d  = state_q;
    s_tready = 1'b0;
    cmd_o    = '0;
    case (state_q)
      ST_IDLE: begin
        s_tready     = 1'b1;
        cmd_o.insert = s_tvalid;
        if (s_tvalid) begin
          state_d = ST_POP;
        end
      end
      ST_POP: begin
        if (!status_i.emit_ok) begin
          state_d = ST_IDLE;
        end else if (status_i.queue_nonempty) begin
          if (status_i.out_free) begin
            cmd_o.pop = 1'b1;
            state_d   = ST_IDLE;
          end
        end else if (status_i.all_exhausted) begin
          if (status_i.out_free) begin
            cmd_o.finish = 1'b1;
            state_d      = ST_IDLE;
          end
        end else begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

@@ design/kwms_dp.sv @@
// sorted shift-register queue, merge bookkeeping and output register
module kwms_dp
  import kwms_pkg::*;
#(
  parameter int unsigned MAX_SOURCES = DefMaxSources
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  dp_cmd_t                   cmd_i,
  output dp_status_t                status_o,
  input  logic [NumSrcW-1:0]        count_i,
  input  logic signed [ValueW-1:0]  in_value_i,
  input  logic [SourceW-1:0]        in_source_i,
  input  logic                      in_at_end_i,
  output logic                      m_tvalid,
  input  logic                      m_tready,
  output logic signed [ValueW-1:0]  m_tdata,
  output logic [SourceW-1:0]        m_tuser,
  output logic                      m_tlast
);

  localparam int unsigned OccW = $clog2(MAX_SOURCES + 1);

  logic signed [ValueW-1:0] qv_q [MAX_SOURCES];
  logic [SourceW-1:0]       qs_q [MAX_SOURCES];
  logic [OccW-1:0]          occ_q, occ_d;
  logic [NumSrcW-1:0]       primed_q, primed_d;
  logic [MaskW-1:0]         exh_q, exh_d;
  logic                     emit_ok_q, emit_ok_d;
  logic [MAX_SOURCES-1:0]   keep;
  logic [MaskW-1:0]         need;
  logic                     full;
  logic                     do_ins;

  logic                     out_valid_q;
  logic signed [ValueW-1:0] out_value_q;
  logic [SourceW-1:0]       out_source_q;
  logic                     out_finished_q;

  assign full   = (occ_q == OccW'(MAX_SOURCES));
  assign do_ins = cmd_i.insert && !in_at_end_i && !full;

  // entries that stay in place: occupied and not greater than the new value
  always_comb begin
    for (int i = 0; i < MAX_SOURCES; i++) begin
      keep[i] = (OccW'(i) < occ_q) && !(qv_q[i] > in_value_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_ins) begin
      if (!keep[0]) begin
        qv_q[0] <= in_value_i;
        qs_q[0] <= in_source_i;
      end
      for (int i = 1; i < MAX_SOURCES; i++) begin
        if (keep[i]) begin
          qv_q[i] <= qv_q[i];
          qs_q[i] <= qs_q[i];
        end else if (keep[i-1]) begin
          qv_q[i] <= in_value_i;
          qs_q[i] <= in_source_i;
        end else begin
          qv_q[i] <= qv_q[i-1];
          qs_q[i] <= qs_q[i-1];
        end
      end
    end else if (cmd_i.pop) begin
      for (int i = 0; i < MAX_SOURCES - 1; i++) begin
        qv_q[i] <= qv_q[i+1];
        qs_q[i] <= qs_q[i+1];
      end
    end
  end

  always_comb begin
    occ_d     = occ_q;
    primed_d  = primed_q;
    exh_d     = exh_q;
    emit_ok_d = emit_ok_q;
    if (cmd_i.insert) begin
      if (in_at_end_i) begin
        exh_d = exh_q | (MaskW'(1) << in_source_i);
      end else if (!full) begin
        occ_d = occ_q + OccW'(1);
      end
      emit_ok_d = (primed_q >= count_i) ||
                  ({1'b0, primed_q} + (NumSrcW + 1)'(1) >= {1'b0, count_i});
      if (primed_q < count_i) begin
        primed_d = primed_q + NumSrcW'(1);
      end
    end else if (cmd_i.pop) begin
      occ_d = occ_q - OccW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q     <= '0;
      primed_q  <= '0;
      exh_q     <= '0;
      emit_ok_q <= 1'b0;
    end else begin
      occ_q     <= occ_d;
      primed_q  <= primed_d;
      exh_q     <= exh_d;
      emit_ok_q <= emit_ok_d;
    end
  end

  always_comb begin
    for (int j = 0; j < MaskW; j++) begin
      need[j] = (NumSrcW'(j) < count_i);
    end
  end

  assign status_o.emit_ok        = emit_ok_q;
  assign status_o.queue_nonempty = (occ_q != '0);
  assign status_o.all_exhausted  = &(exh_q | ~need);
  assign status_o.out_free       = !out_valid_q || m_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.pop || cmd_i.finish) begin
      out_valid_q <= 1'b1;
    end else if (m_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.pop) begin
      out_value_q    <= qv_q[0];
      out_source_q   <= qs_q[0];
      out_finished_q <= 1'b0;
    end else if (cmd_i.finish) begin
      out_value_q    <= '0;
      out_source_q   <= '0;
      out_finished_q <= 1'b1;
    end
  end

  assign m_tvalid = out_valid_q;
  assign m_tdata  = out_value_q;
  assign m_tuser  = out_source_q;
  assign m_tlast  = out_finished_q;

endmodule

@@ design/k_way_merge_selector_unit.sv @@
// top level of the k-way merge selector
//
// Merges up to 16 ascending signed 64-bit streams through a sorted queue of
// MAX_SOURCES entries held in shift registers. An accepted request, unless it
// is at_end, is inserted in the same cycle by a parallel compare against every
// queued entry, and the following cycle pops the head into the output register;
// the pop cycle is held for as long as the output register still carries an
// earlier result that has not been taken. Equal values leave in arrival order.
// No result is given until num_sources requests have arrived; once all
// configured sources are exhausted and the queue is empty a request returns
// one result with m_tlast (finished) set and zero data.
module k_way_merge_selector_unit
  import kwms_pkg::*;
#(
  parameter int unsigned MAX_SOURCES = DefMaxSources
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [ApbAddrW-1:0]  paddr,
  input  logic [ApbDataW-1:0]  pwdata,
  output logic [ApbDataW-1:0]  prdata,
  output logic                 pready,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [ValueW-1:0]    s_tdata,   // [63:0] value
  input  logic [SourceW-1:0]   s_tuser,   // [3:0] source
  input  logic                 s_tlast,   // at_end
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [ValueW-1:0]    m_tdata,   // [63:0] min_value
  output logic [SourceW-1:0]   m_tuser,   // [3:0] min_source
  output logic                 m_tlast    // finished
);

  localparam int unsigned MaxCount = (MAX_SOURCES < 16) ? MAX_SOURCES : 16;

  logic [NumSrcW-1:0] num_sources_q;
  logic [NumSrcW-1:0] count;
  logic               reg_sel;
  dp_cmd_t            cmd;
  dp_status_t         status;

  assign pready  = 1'b1;
  assign reg_sel = (paddr[ApbAddrW-1:2] == RegNumSources);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_sources_q <= NumSrcW'(1);
    end else if (psel && penable && pwrite && reg_sel) begin
      num_sources_q <= pwdata[NumSrcW-1:0];
    end
  end

  assign prdata = reg_sel ? ApbDataW'(num_sources_q) : '0;

  // effective source count, clamped to the supported range
  always_comb begin
    if (num_sources_q == '0) begin
      count = NumSrcW'(1);
    end else if (num_sources_q > NumSrcW'(MaxCount)) begin
      count = NumSrcW'(MaxCount);
    end else begin
      count = num_sources_q;
    end
  end

  kwms_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status_i (status),
    .cmd_o    (cmd)
  );

  kwms_dp #(
    .MAX_SOURCES (MAX_SOURCES)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .count_i     (count),
    .in_value_i  (s_tdata),
    .in_source_i (s_tuser),
    .in_at_end_i (s_tlast),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser),
    .m_tlast     (m_tlast)
  );

endmodule

@@ design/kwms_checker.sv @@
// port-level checks of the k-way merge selector, bound to the top level
module kwms_checker
  import kwms_pkg::*;
(
  input logic                clk_i,
  input logic                rst_ni,
  input logic                s_tvalid,
  input logic                s_tready,
  input logic                m_tvalid,
  input logic                m_tready,
  input logic [ValueW-1:0]   m_tdata,
  input logic [SourceW-1:0]  m_tuser,
  input logic                m_tlast
);

  // a finished result carries no element
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid && m_tlast |-> m_tdata == '0 && m_tuser == '0)
    else $error("finished result with nonzero payload");

  // an accepted request is followed by a busy pop cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_tvalid && s_tready |=> !s_tready)
    else $error("request taken during pop cycle");

  // a result only appears from a pop cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_tvalid) |-> !$past(s_tready))
    else $error("result appeared outside a pop cycle");

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("stalled result changed");

endmodule

bind k_way_merge_selector_unit kwms_checker u_kwms_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);
